>>> design/dwc_pkg.sv
// Shared types and constants for the stride-2 depthwise 3x3 convolution block.
package dwc_pkg;

	localparam int SMP_W  = 16;
	localparam int TAP_W  = 16;
	localparam int PROD_W = 32;
	localparam int ROW_W  = 34;
	localparam int ACC_W  = 36;
	localparam int Q_W    = ACC_W - 13;
	localparam int CFG_W  = 48;
	localparam int IDX_W  = 3;

	localparam logic [IDX_W-1:0] REG_TAPS_TOP = 3'd0;
	localparam logic [IDX_W-1:0] REG_TAPS_MID = 3'd1;
	localparam logic [IDX_W-1:0] REG_TAPS_BOT = 3'd2;
	localparam logic [IDX_W-1:0] REG_BIAS     = 3'd3;
	localparam logic [IDX_W-1:0] REG_CLAMP_LO = 3'd4;
	localparam logic [IDX_W-1:0] REG_CLAMP_HI = 3'd5;
	localparam logic [IDX_W-1:0] REG_PAD_TOP  = 3'd6;
	localparam logic [IDX_W-1:0] REG_HEIGHT   = 3'd7;

	// which rows feed the window on this input row
	localparam logic [1:0] MODE_NONE     = 2'd0;
	localparam logic [1:0] MODE_FULL     = 2'd1;
	localparam logic [1:0] MODE_LAST_ODD = 2'd2;
	localparam logic [1:0] MODE_SINGLE   = 2'd3;

	typedef logic signed [SMP_W-1:0]  smp_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ROW_W-1:0]  rsum_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	typedef struct packed {
		logic       row_end;
		logic       last_row;
		logic       col_odd;
		logic [1:0] mode;
		logic       r1_ok;
		logic       r2_ok;
		logic       in_range;
	} ctl_t;

	typedef struct packed {
		logic row_end;
		logic frame_end;
	} endf_t;

endpackage

>>> design/dwc_line_store.sv
// Two line stores kept as one memory word per column, with write-to-read bypass.
module dwc_line_store import dwc_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int AW = $clog2(MAX_WIDTH)
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic [2*SMP_W-1:0]   wr_data,
	output logic [2*SMP_W-1:0]   rd_data
);

	logic [2*SMP_W-1:0] mem [MAX_WIDTH];
	logic [2*SMP_W-1:0] rd_q;
	logic [2*SMP_W-1:0] byp_data_q;
	logic               byp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			byp_q      <= wr_en && (wr_addr == rd_addr);
			byp_data_q <= wr_data;
		end
	end

	assign rd_data = byp_q ? byp_data_q : rd_q;

endmodule

>>> design/dwc_window.sv
// Column window, row selection and the nine tap products.
module dwc_window import dwc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                v_s1,
	input  ctl_t                ctl_s1,
	input  smp_t                pix_s1,
	input  logic [2*SMP_W-1:0]  line_s1,
	input  logic [CFG_W-1:0]    taps [3],
	output logic                fire,
	output prod_t               prod_s2 [3][3]
);

	smp_t win_l_q [3];
	smp_t win_c_q [3];
	smp_t r1;
	smp_t r2;
	smp_t v     [3];
	smp_t use_c [3];
	smp_t use_r [3];

	always_comb begin
		r1 = ctl_s1.r1_ok ? smp_t'(line_s1[SMP_W-1:0]) : '0;
		r2 = ctl_s1.r2_ok ? smp_t'(line_s1[2*SMP_W-1:SMP_W]) : '0;
		case (ctl_s1.mode)
			MODE_FULL: begin
				v[0] = r2;
				v[1] = r1;
				v[2] = pix_s1;
			end
			MODE_LAST_ODD: begin
				v[0] = r1;
				v[1] = pix_s1;
				v[2] = '0;
			end
			MODE_SINGLE: begin
				v[0] = pix_s1;
				v[1] = '0;
				v[2] = '0;
			end
			default: begin
				v[0] = '0;
				v[1] = '0;
				v[2] = '0;
			end
		endcase
		for (int r = 0; r < 3; r++) begin
			use_c[r] = ctl_s1.col_odd ? win_c_q[r] : v[r];
			use_r[r] = ctl_s1.col_odd ? v[r] : '0;
		end
	end

	assign fire = (ctl_s1.col_odd || ctl_s1.row_end) && (ctl_s1.mode != MODE_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				win_l_q[r] <= '0;
				win_c_q[r] <= '0;
			end
		end else if (adv && v_s1) begin
			for (int r = 0; r < 3; r++) begin
				if (ctl_s1.row_end) begin
					win_l_q[r] <= '0;
					win_c_q[r] <= '0;
				end else if (ctl_s1.col_odd) begin
					win_l_q[r] <= v[r];
				end else begin
					win_c_q[r] <= v[r];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				prod_s2[r][0] <= smp_t'(taps[r][15:0])  * win_l_q[r];
				prod_s2[r][1] <= smp_t'(taps[r][31:16]) * use_c[r];
				prod_s2[r][2] <= smp_t'(taps[r][47:32]) * use_r[r];
			end
		end
	end

endmodule

>>> design/dwc_mac.sv
// Adder stages, rounding, clamping and the output register.
module dwc_mac import dwc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 v_s2,
	input  endf_t                endf_s2,
	input  prod_t                prod_s2 [3][3],
	input  logic signed [31:0]   bias,
	input  smp_t                 clamp_lo,
	input  smp_t                 clamp_hi,
	output logic                 valid_q,
	output smp_t                 result_q,
	output endf_t                endf_q
);

	rsum_t rsum_s3 [3];
	logic  v_s3;
	endf_t endf_s3;
	acc_t  acc_s4;
	logic  v_s4;
	endf_t endf_s4;
	logic signed [Q_W-1:0] q;
	logic signed [Q_W-1:0] q_lo;
	logic signed [Q_W-1:0] q_hi;

	always_comb begin
		q = Q_W'(acc_s4 >>> 13);
		if (q < Q_W'(clamp_lo)) begin
			q_lo = Q_W'(clamp_lo);
		end else begin
			q_lo = q;
		end
		if (q_lo > Q_W'(clamp_hi)) begin
			q_hi = Q_W'(clamp_hi);
		end else begin
			q_hi = q_lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			valid_q <= 1'b0;
		end else if (adv) begin
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				rsum_s3[r] <= ROW_W'(prod_s2[r][0]) + ROW_W'(prod_s2[r][1])
					+ ROW_W'(prod_s2[r][2]);
			end
			endf_s3  <= endf_s2;
			acc_s4   <= ACC_W'(rsum_s3[0]) + ACC_W'(rsum_s3[1]) + ACC_W'(rsum_s3[2])
				+ ACC_W'(bias) + ACC_W'(4096);
			endf_s4  <= endf_s3;
			result_q <= q_hi[SMP_W-1:0];
			endf_q   <= endf_s4;
		end
	end

endmodule

>>> design/depthwise_conv3x3_stride2_pad1.sv
// Top level: stride-2 depthwise 3x3 convolution over a raster pixel stream.
// A result is registered in turn at s1, the products (s2), the row sums (s3), the accumulator (s4) and the output.
// Throughput: one pixel beat per cycle while in_stall is low; the line store has separate read and write ports.
// The whole pipeline holds while a result waits on out_stall.
// Reset clears counters, window and valid bits and sets configuration to defaults; line stores are not cleared.
module depthwise_conv3x3_stride2_pad1 import dwc_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [SMP_W-1:0] pixel,
	input  logic                    row_end,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [SMP_W-1:0] result,
	output logic                    out_row_end,
	output logic                    out_frame_end,
	input  logic                    cfg_wr_en,
	input  logic [IDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);

	logic [CFG_W-1:0]   taps_q [3];
	logic signed [31:0] bias_q;
	smp_t               clamp_lo_q;
	smp_t               clamp_hi_q;
	logic               pad_top_q;
	logic [15:0]        height_q;

	logic [CW-1:0]      col_q;
	logic               col_odd_q;
	logic [15:0]        row_q;

	logic               adv;
	logic               accept;
	logic [15:0]        h_eff;
	logic               last_row;
	logic [16:0]        p;
	ctl_t               ctl_in;

	logic               v_s1;
	ctl_t               ctl_s1;
	smp_t               pix_s1;
	logic [AW-1:0]      addr_s1;
	logic [2*SMP_W-1:0] line_s1;

	logic               fire;
	prod_t              prod_s2 [3][3];
	logic               v_s2;
	endf_t              endf_s2;
	endf_t              endf_q;
	smp_t               result_q;

	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;
	assign accept   = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q[0]  <= '0;
			taps_q[1]  <= '0;
			taps_q[2]  <= '0;
			bias_q     <= '0;
			clamp_lo_q <= 16'sh8000;
			clamp_hi_q <= 16'sh7FFF;
			pad_top_q  <= 1'b1;
			height_q   <= 16'd1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TAPS_TOP: taps_q[0]  <= cfg_data;
				REG_TAPS_MID: taps_q[1]  <= cfg_data;
				REG_TAPS_BOT: taps_q[2]  <= cfg_data;
				REG_BIAS:     bias_q     <= cfg_data[31:0];
				REG_CLAMP_LO: clamp_lo_q <= cfg_data[15:0];
				REG_CLAMP_HI: clamp_hi_q <= cfg_data[15:0];
				REG_PAD_TOP:  pad_top_q  <= cfg_data[0];
				REG_HEIGHT:   height_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		h_eff           = (height_q == 16'd0) ? 16'd1 : height_q;
		last_row        = row_q >= (h_eff - 16'd1);
		p               = {1'b0, row_q} + {16'd0, pad_top_q};
		ctl_in.row_end  = row_end;
		ctl_in.last_row = last_row;
		ctl_in.col_odd  = col_odd_q;
		ctl_in.in_range = col_q < CW'(MAX_WIDTH);
		ctl_in.r1_ok    = ctl_in.in_range && (row_q >= 16'd1);
		ctl_in.r2_ok    = ctl_in.in_range && (row_q >= 16'd2);
		if (!p[0] && (p[16:1] != '0)) begin
			ctl_in.mode = MODE_FULL;
		end else if (p[0] && last_row) begin
			ctl_in.mode = MODE_LAST_ODD;
		end else if ((p == '0) && last_row) begin
			ctl_in.mode = MODE_SINGLE;
		end else begin
			ctl_in.mode = MODE_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			col_odd_q <= 1'b0;
			row_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
		end else begin
			if (accept) begin
				if (row_end) begin
					col_q     <= '0;
					col_odd_q <= 1'b0;
					row_q     <= last_row ? 16'd0 : row_q + 16'd1;
				end else begin
					if (ctl_in.in_range) begin
						col_q <= col_q + CW'(1);
					end
					col_odd_q <= !col_odd_q;
				end
			end
			if (adv) begin
				v_s1 <= in_valid;
				v_s2 <= v_s1 && fire;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1            <= ctl_in;
			pix_s1            <= pixel;
			addr_s1           <= col_q[AW-1:0];
			endf_s2.row_end   <= ctl_s1.row_end;
			endf_s2.frame_end <= ctl_s1.row_end && ctl_s1.last_row;
		end
	end

	dwc_line_store #(
		.MAX_WIDTH (MAX_WIDTH),
		.AW        (AW)
	) u_line (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q[AW-1:0]),
		.wr_en   (adv && v_s1 && ctl_s1.in_range),
		.wr_addr (addr_s1),
		.wr_data ({line_s1[SMP_W-1:0], pix_s1}),
		.rd_data (line_s1)
	);

	dwc_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.v_s1    (v_s1),
		.ctl_s1  (ctl_s1),
		.pix_s1  (pix_s1),
		.line_s1 (line_s1),
		.taps    (taps_q),
		.fire    (fire),
		.prod_s2 (prod_s2)
	);

	dwc_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.v_s2     (v_s2),
		.endf_s2  (endf_s2),
		.prod_s2  (prod_s2),
		.bias     (bias_q),
		.clamp_lo (clamp_lo_q),
		.clamp_hi (clamp_hi_q),
		.valid_q  (out_valid),
		.result_q (result_q),
		.endf_q   (endf_q)
	);

	assign result        = result_q;
	assign out_row_end   = endf_q.row_end;
	assign out_frame_end = endf_q.frame_end;

endmodule
